// File: design/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task table scheduler package
// Shared types, codes and constants for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int DEF_SLOTS  = 16;
  localparam int WORD_W     = 32;
  localparam int SLOT_OUT_W = 4;
  localparam int LIVE_OUT_W = 5;

  localparam logic [WORD_W-1:0] BOOT_ID      = 32'd1;
  localparam logic [WORD_W-1:0] NEXT_ID_INIT = 32'd2;

  typedef enum logic [1:0] {
    PH_UNUSED  = 2'd0,
    PH_READY   = 2'd1,
    PH_RUNNING = 2'd2,
    PH_ZOMBIE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OP_SCHED  = 2'd0,
    OP_CREATE = 2'd1,
    OP_EXIT   = 2'd2,
    OP_SET    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_BAD_ARG = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SAVE,
    S_SCAN,
    S_CSCAN,
    S_EXIT,
    S_SETCHK,
    S_SETAPP,
    S_READ,
    S_DONE
  } state_t;

  // Result of one scan step
  typedef struct packed {
    logic hit;
    logic last;
  } scan_flags_t;

  // One phase write port (index travels beside it)
  typedef struct packed {
    logic   en;
    phase_t ph;
  } phase_wr_t;

  // Slot memory write group
  typedef struct packed {
    logic              frame_en;
    logic              task_en;
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] frame;
    logic [WORD_W-1:0] space;
  } mem_wr_t;

endpackage

// File: design/task_table_round_robin_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task table scheduler
// Task slot table with schedule, create, exit and set-current operations.
// ----------------------------------------------------------------------------
// One item is in flight at a time; in_stall is low only while the sequencer
// is idle. Every item gives exactly one result, held in an output register so
// the next item may be taken while that result waits. With N = SLOTS, a
// schedule tick saves the frame in S_SAVE, then scans from 1 to N slots in
// S_SCAN; a create scans for the lowest unused slot (at most N) in S_CSCAN;
// an exit passes S_EXIT; a set-current passes S_SETCHK and S_SETAPP, skipping
// S_SETAPP when the target lies beyond the table. Every item then passes
// S_READ and S_DONE, where it waits for the result register to be free. The
// scan runs through the one shared compare-and-advance unit, which looks at
// one slot phase per cycle. Slot 0 is the bootstrap task: its id is fixed at
// 1, its space is the kernel_space register, and it never exits. Freed slots
// are not scrubbed; a create always rewrites the id, frame and space of the
// slot it takes. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module task_table_round_robin_scheduler #(
  parameter int SLOTS = tts_pkg::DEF_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_frame_in,
  input  logic [31:0] in_address_space,
  input  logic        in_resources_ok,
  input  logic [3:0]  in_target_slot,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_switched,
  output logic [3:0]  out_slot_out,
  output logic [31:0] out_id_out,
  output logic [31:0] out_frame_out,
  output logic [31:0] out_space_out,
  output logic        out_reaped,
  output logic [3:0]  out_reaped_slot,
  output logic [4:0]  out_live_count
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int WW = tts_pkg::WORD_W;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  tts_pkg::state_t  state_r, state_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic [LW-1:0]    live_r, live_nxt;
  logic [WW-1:0]    next_id_r, next_id_nxt;
  logic [WW-1:0]    kernel_space_r;
  logic             out_valid_r, out_valid_nxt;

  // Per-item working registers
  logic [WW-1:0]    frame_in_r, frame_in_nxt;
  logic [WW-1:0]    space_in_r, space_in_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [3:0]       tgt_r, tgt_nxt;
  logic [IW-1:0]    prev_r, prev_nxt;
  tts_pkg::phase_t  pphase_r, pphase_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [IW-1:0]    cnt_r, cnt_nxt;
  tts_pkg::status_t status_r, status_nxt;
  logic             created_r, created_nxt;
  logic [IW-1:0]    new_slot_r, new_slot_nxt;
  logic [WW-1:0]    new_id_r, new_id_nxt;
  logic             reaped_r, reaped_nxt;
  logic [IW-1:0]    reaped_slot_r, reaped_slot_nxt;

  // Result register
  logic [1:0]       out_status_r;
  logic             out_switched_r;
  logic [3:0]       out_slot_r;
  logic [WW-1:0]    out_id_r;
  logic [WW-1:0]    out_frame_r;
  logic [WW-1:0]    out_space_r;
  logic             out_reaped_r;
  logic [3:0]       out_reaped_slot_r;
  logic [4:0]       out_live_r;
  logic             out_load;

  // --------------------------------------------------------------------------
  // Table and scan unit hookup
  // --------------------------------------------------------------------------
  logic [IW-1:0]        prd_addr;
  tts_pkg::phase_t      phase_rd;
  tts_pkg::phase_wr_t   pwa, pwb;
  logic [IW-1:0]        pwa_idx, pwb_idx;
  logic [IW-1:0]        raddr;
  logic [WW-1:0]        id_rd, frame_rd, space_rd;
  logic [IW-1:0]        wr_idx;
  tts_pkg::mem_wr_t     mem_wr;

  logic [IW-1:0]        scan_idx;
  tts_pkg::phase_t      scan_want;
  tts_pkg::scan_flags_t scan_flags;
  logic [IW-1:0]        scan_next;

  logic [IW-1:0]        tgt_idx;
  logic                 tgt_beyond;
  logic                 accept;

  assign tgt_idx    = IW'(tgt_r);
  assign tgt_beyond = (32'(tgt_r) >= SLOTS);
  assign accept     = in_valid && (state_r == tts_pkg::S_IDLE);
  assign in_stall   = (state_r != tts_pkg::S_IDLE);

  tts_slot_table #(.SLOTS(SLOTS)) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .kernel_space (kernel_space_r),
    .prd_addr     (prd_addr),
    .phase_rd     (phase_rd),
    .pwa          (pwa),
    .pwa_idx      (pwa_idx),
    .pwb          (pwb),
    .pwb_idx      (pwb_idx),
    .raddr        (raddr),
    .id_rd        (id_rd),
    .frame_rd     (frame_rd),
    .space_rd     (space_rd),
    .wr_idx       (wr_idx),
    .mem_wr       (mem_wr)
  );

  // Shared step unit: walks from the current slot in the save cycle,
  // otherwise from the running scan index
  assign scan_idx  = (state_r == tts_pkg::S_SAVE) ? cur_r : idx_r;
  assign scan_want = (state_r == tts_pkg::S_CSCAN) ? tts_pkg::PH_UNUSED
                                                   : tts_pkg::PH_READY;

  tts_scan_unit #(.SLOTS(SLOTS)) u_scan (
    .idx      (scan_idx),
    .step     (cnt_r),
    .phase    (phase_rd),
    .want     (scan_want),
    .flags    (scan_flags),
    .next_idx (scan_next)
  );

  // Phase read port: scanning index, target on apply, current otherwise
  always_comb begin
    unique case (state_r)
      tts_pkg::S_SCAN,
      tts_pkg::S_CSCAN:  prd_addr = idx_r;
      tts_pkg::S_SETAPP: prd_addr = tgt_idx;
      default:           prd_addr = cur_r;
    endcase
  end

  // Memory read address: target space on the check, current slot otherwise
  assign raddr = (state_r == tts_pkg::S_SETCHK) ? tgt_idx : cur_r;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    live_nxt        = live_r;
    next_id_nxt     = next_id_r;
    frame_in_nxt    = frame_in_r;
    space_in_nxt    = space_in_r;
    res_ok_nxt      = res_ok_r;
    tgt_nxt         = tgt_r;
    prev_nxt        = prev_r;
    pphase_nxt      = pphase_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    status_nxt      = status_r;
    created_nxt     = created_r;
    new_slot_nxt    = new_slot_r;
    new_id_nxt      = new_id_r;
    reaped_nxt      = reaped_r;
    reaped_slot_nxt = reaped_slot_r;

    pwa     = '{en: 1'b0, ph: tts_pkg::PH_UNUSED};
    pwb     = '{en: 1'b0, ph: tts_pkg::PH_UNUSED};
    pwa_idx = prev_r;
    pwb_idx = idx_r;
    wr_idx  = idx_r;
    mem_wr  = '{frame_en: 1'b0, task_en: 1'b0, id: next_id_r,
                frame: frame_in_r, space: space_in_r};
    out_load = 1'b0;

    unique case (state_r)
      tts_pkg::S_IDLE: begin
        if (accept) begin
          // capture the item and clear the per-item flags
          frame_in_nxt    = in_frame_in;
          space_in_nxt    = in_address_space;
          res_ok_nxt      = in_resources_ok;
          tgt_nxt         = in_target_slot;
          prev_nxt        = cur_r;
          status_nxt      = tts_pkg::ST_OK;
          created_nxt     = 1'b0;
          reaped_nxt      = 1'b0;
          reaped_slot_nxt = '0;
          idx_nxt         = '0;
          cnt_nxt         = '0;
          unique case (tts_pkg::opcode_t'(in_opcode))
            tts_pkg::OP_SCHED:  state_nxt = tts_pkg::S_SAVE;
            tts_pkg::OP_CREATE: state_nxt = tts_pkg::S_CSCAN;
            tts_pkg::OP_EXIT:   state_nxt = tts_pkg::S_EXIT;
            tts_pkg::OP_SET:    state_nxt = tts_pkg::S_SETCHK;
            default:            state_nxt = tts_pkg::S_IDLE;
          endcase
        end
      end

      tts_pkg::S_SAVE: begin
        // save the frame of a running task, start the scan after it
        pphase_nxt = phase_rd;
        if (phase_rd == tts_pkg::PH_RUNNING) begin
          wr_idx          = cur_r;
          mem_wr.frame_en = 1'b1;
        end
        idx_nxt   = scan_next;
        cnt_nxt   = '0;
        state_nxt = tts_pkg::S_SCAN;
      end

      tts_pkg::S_SCAN: begin
        if (scan_flags.hit) begin
          cur_nxt = idx_r;
          pwb     = '{en: 1'b1, ph: tts_pkg::PH_RUNNING};
          pwb_idx = idx_r;
          if (idx_r != prev_r) begin
            if (pphase_r == tts_pkg::PH_RUNNING) begin
              pwa = '{en: 1'b1, ph: tts_pkg::PH_READY};
            end else if (pphase_r == tts_pkg::PH_ZOMBIE) begin
              // reap the zombie we just left
              pwa             = '{en: 1'b1, ph: tts_pkg::PH_UNUSED};
              reaped_nxt      = 1'b1;
              reaped_slot_nxt = prev_r;
              if (live_r != '0) begin
                live_nxt = live_r - LW'(1);
              end
            end
          end
          state_nxt = tts_pkg::S_READ;
        end else if (scan_flags.last) begin
          if (pphase_r == tts_pkg::PH_ZOMBIE) begin
            // nothing ready: fall back to the bootstrap task
            cur_nxt = '0;
            pwb     = '{en: 1'b1, ph: tts_pkg::PH_RUNNING};
            pwb_idx = '0;
            if (prev_r != '0) begin
              pwa             = '{en: 1'b1, ph: tts_pkg::PH_UNUSED};
              reaped_nxt      = 1'b1;
              reaped_slot_nxt = prev_r;
              if (live_r != '0) begin
                live_nxt = live_r - LW'(1);
              end
            end
          end else begin
            pwb     = '{en: 1'b1, ph: tts_pkg::PH_RUNNING};
            pwb_idx = prev_r;
          end
          state_nxt = tts_pkg::S_READ;
        end else begin
          idx_nxt = scan_next;
          cnt_nxt = cnt_r + IW'(1);
        end
      end

      tts_pkg::S_CSCAN: begin
        if (scan_flags.hit) begin
          if (space_in_r == '0 || !res_ok_r) begin
            status_nxt = tts_pkg::ST_BAD_ARG;
          end else begin
            wr_idx          = idx_r;
            mem_wr.frame_en = 1'b1;
            mem_wr.task_en  = 1'b1;
            pwb             = '{en: 1'b1, ph: tts_pkg::PH_READY};
            pwb_idx         = idx_r;
            new_slot_nxt    = idx_r;
            new_id_nxt      = next_id_r;
            created_nxt     = 1'b1;
            live_nxt        = live_r + LW'(1);
            // skip zero and the bootstrap id on wrap
            if (next_id_r == '1) begin
              next_id_nxt = tts_pkg::NEXT_ID_INIT;
            end else begin
              next_id_nxt = next_id_r + WW'(1);
            end
          end
          state_nxt = tts_pkg::S_READ;
        end else if (scan_flags.last) begin
          status_nxt = tts_pkg::ST_NO_SLOT;
          state_nxt  = tts_pkg::S_READ;
        end else begin
          idx_nxt = scan_next;
          cnt_nxt = cnt_r + IW'(1);
        end
      end

      tts_pkg::S_EXIT: begin
        // the bootstrap task never exits
        if (cur_r != '0) begin
          pwb     = '{en: 1'b1, ph: tts_pkg::PH_ZOMBIE};
          pwb_idx = cur_r;
        end
        state_nxt = tts_pkg::S_READ;
      end

      tts_pkg::S_SETCHK: begin
        pphase_nxt = phase_rd;
        if (tgt_beyond) begin
          status_nxt = tts_pkg::ST_BAD_ARG;
          state_nxt  = tts_pkg::S_READ;
        end else begin
          state_nxt = tts_pkg::S_SETAPP;
        end
      end

      tts_pkg::S_SETAPP: begin
        if (phase_rd == tts_pkg::PH_UNUSED || space_rd == '0) begin
          status_nxt = tts_pkg::ST_BAD_ARG;
        end else begin
          if (cur_r != tgt_idx && pphase_r == tts_pkg::PH_RUNNING) begin
            pwa     = '{en: 1'b1, ph: tts_pkg::PH_READY};
            pwa_idx = cur_r;
          end
          // a zombie target comes back to life and is not reaped
          pwb     = '{en: 1'b1, ph: tts_pkg::PH_RUNNING};
          pwb_idx = tgt_idx;
          cur_nxt = tgt_idx;
        end
        state_nxt = tts_pkg::S_READ;
      end

      tts_pkg::S_READ: begin
        state_nxt = tts_pkg::S_DONE;
      end

      tts_pkg::S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = tts_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tts_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= tts_pkg::S_IDLE;
      cur_r          <= '0;
      live_r         <= LW'(1);
      next_id_r      <= tts_pkg::NEXT_ID_INIT;
      kernel_space_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      live_r      <= live_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        kernel_space_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    frame_in_r    <= frame_in_nxt;
    space_in_r    <= space_in_nxt;
    res_ok_r      <= res_ok_nxt;
    tgt_r         <= tgt_nxt;
    prev_r        <= prev_nxt;
    pphase_r      <= pphase_nxt;
    idx_r         <= idx_nxt;
    cnt_r         <= cnt_nxt;
    status_r      <= status_nxt;
    created_r     <= created_nxt;
    new_slot_r    <= new_slot_nxt;
    new_id_r      <= new_id_nxt;
    reaped_r      <= reaped_nxt;
    reaped_slot_r <= reaped_slot_nxt;
  end

  // --------------------------------------------------------------------------
  // Result register: memories were read at the final current slot in S_READ
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r      <= status_r;
      out_switched_r    <= (cur_r != prev_r);
      out_slot_r        <= created_r ? 4'(new_slot_r) : 4'(cur_r);
      out_id_r          <= created_r ? new_id_r : id_rd;
      out_frame_r       <= (cur_r != prev_r) ? frame_rd : frame_in_r;
      out_space_r       <= space_rd;
      out_reaped_r      <= reaped_r;
      out_reaped_slot_r <= 4'(reaped_slot_r);
      out_live_r        <= 5'(live_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_switched    = out_switched_r;
  assign out_slot_out    = out_slot_r;
  assign out_id_out      = out_id_r;
  assign out_frame_out   = out_frame_r;
  assign out_space_out   = out_space_r;
  assign out_reaped      = out_reaped_r;
  assign out_reaped_slot = out_reaped_slot_r;
  assign out_live_count  = out_live_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_live_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    live_r != '0 && 32'(live_r) <= SLOTS)
    else $error("live slot count out of range");

  a_next_id_floor: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r >= tts_pkg::NEXT_ID_INIT)
    else $error("next id fell below the first task id");

  a_reap_switches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_reaped_r |-> out_switched_r && out_status_r == tts_pkg::ST_OK)
    else $error("reap reported without a task switch");

endmodule

// File: design/tts_scan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan step unit
// Compares one slot phase against the wanted phase and advances the index.
// ----------------------------------------------------------------------------
module tts_scan_unit #(
  parameter int SLOTS = tts_pkg::DEF_SLOTS
) (
  input  logic [$clog2(SLOTS)-1:0] idx,
  input  logic [$clog2(SLOTS)-1:0] step,
  input  tts_pkg::phase_t          phase,
  input  tts_pkg::phase_t          want,
  output tts_pkg::scan_flags_t     flags,
  output logic [$clog2(SLOTS)-1:0] next_idx
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] TOP_IDX = IW'(SLOTS - 1);

  always_comb begin
    flags.hit  = (phase == want);
    flags.last = (step == TOP_IDX);
    // wrap at the top slot
    if (idx == TOP_IDX) begin
      next_idx = '0;
    end else begin
      next_idx = idx + IW'(1);
    end
  end

endmodule

// File: design/tts_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table
// Phase flops per slot plus id, frame and space memories with registered read.
// ----------------------------------------------------------------------------
module tts_slot_table #(
  parameter int SLOTS = tts_pkg::DEF_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tts_pkg::WORD_W-1:0]      kernel_space,
  input  logic [$clog2(SLOTS)-1:0]        prd_addr,
  output tts_pkg::phase_t                 phase_rd,
  input  tts_pkg::phase_wr_t              pwa,
  input  logic [$clog2(SLOTS)-1:0]        pwa_idx,
  input  tts_pkg::phase_wr_t              pwb,
  input  logic [$clog2(SLOTS)-1:0]        pwb_idx,
  input  logic [$clog2(SLOTS)-1:0]        raddr,
  output logic [tts_pkg::WORD_W-1:0]      id_rd,
  output logic [tts_pkg::WORD_W-1:0]      frame_rd,
  output logic [tts_pkg::WORD_W-1:0]      space_rd,
  input  logic [$clog2(SLOTS)-1:0]        wr_idx,
  input  tts_pkg::mem_wr_t                mem_wr
);

  localparam int IW = $clog2(SLOTS);

  tts_pkg::phase_t                 phase_r [SLOTS];
  logic [tts_pkg::WORD_W-1:0]      id_mem    [SLOTS];
  logic [tts_pkg::WORD_W-1:0]      frame_mem [SLOTS];
  logic [tts_pkg::WORD_W-1:0]      space_mem [SLOTS];
  logic [tts_pkg::WORD_W-1:0]      frame0_r;
  logic [tts_pkg::WORD_W-1:0]      id_rd_r;
  logic [tts_pkg::WORD_W-1:0]      frame_rd_r;
  logic [tts_pkg::WORD_W-1:0]      space_rd_r;

  assign phase_rd = phase_r[prd_addr];
  assign id_rd    = id_rd_r;
  assign frame_rd = frame_rd_r;
  assign space_rd = space_rd_r;

  // Phase flops; port b wins on a shared index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        phase_r[i] <= (i == 0) ? tts_pkg::PH_RUNNING : tts_pkg::PH_UNUSED;
      end
    end else begin
      if (pwa.en) begin
        phase_r[pwa_idx] <= pwa.ph;
      end
      if (pwb.en) begin
        phase_r[pwb_idx] <= pwb.ph;
      end
    end
  end

  // Bootstrap frame holds zero until its first save
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame0_r <= '0;
    end else if (mem_wr.frame_en && wr_idx == '0) begin
      frame0_r <= mem_wr.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr.frame_en) begin
      frame_mem[wr_idx] <= mem_wr.frame;
    end
    if (mem_wr.task_en) begin
      id_mem[wr_idx]    <= mem_wr.id;
      space_mem[wr_idx] <= mem_wr.space;
    end
  end

  // Registered read; slot 0 takes its fixed id and the kernel space
  always_ff @(posedge clk) begin
    if (raddr == IW'(0)) begin
      id_rd_r    <= tts_pkg::BOOT_ID;
      frame_rd_r <= frame0_r;
      space_rd_r <= kernel_space;
    end else begin
      id_rd_r    <= id_mem[raddr];
      frame_rd_r <= frame_mem[raddr];
      space_rd_r <= space_mem[raddr];
    end
  end

  a_boot_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r[0] == tts_pkg::PH_RUNNING || phase_r[0] == tts_pkg::PH_READY)
    else $error("bootstrap slot left the live phases");

  a_phase_ports_apart: assert property (@(posedge clk) disable iff (!rst_n)
    pwa.en && pwb.en |-> pwa_idx != pwb_idx)
    else $error("both phase write ports hit one slot");

endmodule

// File: bench/task_table_round_robin_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task table scheduler testbench
// Drives schedule, create, exit and set-current requests through the input
// channel, predicts every result from a local copy of the task table and
// compares each result transfer field by field, in order, under random
// stalls on both channels and several kernel_space settings.
// ----------------------------------------------------------------------------
module task_table_round_robin_scheduler_test;
  import tts_pkg::*;

  localparam int SLOTS = DEF_SLOTS;
  localparam int DIR_N = 24;
  localparam int PHASE_ITEMS = 250;

  // One request as it travels on the input channel
  typedef struct packed {
    opcode_t     op;
    logic [31:0] frame;
    logic [31:0] space;
    logic        ok;
    logic [3:0]  target;
  } sched_req_t;

  // One result as it travels on the result channel
  typedef struct packed {
    status_t     status;
    logic        switched;
    logic [3:0]  slot;
    logic [31:0] id;
    logic [31:0] frame;
    logic [31:0] space;
    logic        reaped;
    logic [3:0]  reaped_slot;
    logic [4:0]  live;
  } sched_resp_t;

  // Directed row: request, plus a hand-written result where one is obvious
  typedef struct packed {
    sched_req_t  req;
    logic        typed;
    sched_resp_t want;
  } sched_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = OP_SCHED;
  logic [31:0] in_frame_in = 32'd0;
  logic [31:0] in_address_space = 32'd0;
  logic        in_resources_ok = 1'b0;
  logic [3:0]  in_target_slot = 4'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_switched;
  logic [3:0]  out_slot_out;
  logic [31:0] out_id_out;
  logic [31:0] out_frame_out;
  logic [31:0] out_space_out;
  logic        out_reaped;
  logic [3:0]  out_reaped_slot;
  logic [4:0]  out_live_count;

  task_table_round_robin_scheduler #(.SLOTS(SLOTS)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_frame_in     (in_frame_in),
    .in_address_space(in_address_space),
    .in_resources_ok (in_resources_ok),
    .in_target_slot  (in_target_slot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_switched    (out_switched),
    .out_slot_out    (out_slot_out),
    .out_id_out      (out_id_out),
    .out_frame_out   (out_frame_out),
    .out_space_out   (out_space_out),
    .out_reaped      (out_reaped),
    .out_reaped_slot (out_reaped_slot),
    .out_live_count  (out_live_count)
  );

  // --------------------------------------------------------------------------
  // Local copy of the task table, updated as each request transfer happens
  // --------------------------------------------------------------------------
  phase_t      tbl_phase [SLOTS];
  logic [31:0] tbl_id    [SLOTS];
  logic [31:0] tbl_frame [SLOTS];
  logic [31:0] tbl_space [SLOTS];
  logic [3:0]  cur_slot;
  logic [31:0] id_counter;
  int          live_total;
  logic [31:0] kernel_space_m;

  sched_resp_t owed_results [$];
  int          mismatches = 0;
  int          sent = 0;
  int          results_seen = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      tbl_phase[s] = PH_UNUSED;
      tbl_id[s]    = 32'd0;
      tbl_frame[s] = 32'd0;
      tbl_space[s] = 32'd0;
    end
    tbl_phase[0]   = PH_RUNNING;
    tbl_id[0]      = BOOT_ID;
    cur_slot       = 4'd0;
    id_counter     = NEXT_ID_INIT;
    live_total     = 1;
    kernel_space_m = 32'd0;
  end

  // Slot 0 always answers with the kernel_space register
  function automatic logic [31:0] space_of_slot(input logic [3:0] s);
    return (s == 4'd0) ? kernel_space_m : tbl_space[s];
  endfunction

  // Free a zombie slot and scrub it; report whether anything was freed
  function automatic bit reap_if_zombie(input logic [3:0] s);
    if (tbl_phase[s] != PH_ZOMBIE) return 1'b0;
    tbl_phase[s] = PH_UNUSED;
    tbl_id[s]    = 32'd0;
    tbl_frame[s] = 32'd0;
    tbl_space[s] = 32'd0;
    if (live_total > 0) live_total--;
    return 1'b1;
  endfunction

  // Apply one request to the table and return the result it must produce
  function automatic sched_resp_t advance_table(input sched_req_t rq);
    sched_resp_t r;
    logic [3:0]  prev;
    logic [3:0]  idx;
    logic [3:0]  new_slot;
    logic [31:0] new_id;
    bit          found;
    bit          have;
    bit          created;
    int          k;
    r        = '0;
    r.status = ST_OK;
    prev     = cur_slot;
    new_slot = 4'd0;
    new_id   = 32'd0;
    found    = 1'b0;
    have     = 1'b0;
    created  = 1'b0;
    case (rq.op)
      OP_SCHED: begin
        if (tbl_phase[prev] == PH_RUNNING) tbl_frame[prev] = rq.frame;
        // scan after the current slot, wrapping back to it last
        for (k = 1; k <= SLOTS; k++) begin
          idx = prev + k[3:0];
          if (!found && tbl_phase[idx] == PH_READY) begin
            if (tbl_phase[cur_slot] == PH_RUNNING) tbl_phase[cur_slot] = PH_READY;
            cur_slot       = idx;
            tbl_phase[idx] = PH_RUNNING;
            if (prev != idx && reap_if_zombie(prev)) begin
              r.reaped      = 1'b1;
              r.reaped_slot = prev;
            end
            found = 1'b1;
          end
        end
        if (!found) begin
          if (tbl_phase[prev] == PH_ZOMBIE) begin
            // nothing ready behind a dead task: fall back to the bootstrap
            cur_slot     = 4'd0;
            tbl_phase[0] = PH_RUNNING;
            if (reap_if_zombie(prev)) begin
              r.reaped      = 1'b1;
              r.reaped_slot = prev;
            end
          end else begin
            tbl_phase[prev] = PH_RUNNING;
          end
        end
      end
      OP_CREATE: begin
        for (k = 0; k < SLOTS; k++) begin
          if (!have && tbl_phase[k] == PH_UNUSED) begin
            new_slot = k[3:0];
            have     = 1'b1;
          end
        end
        // a full table wins over a bad argument
        if (!have) begin
          r.status = ST_NO_SLOT;
        end else if (rq.space == 32'd0 || !rq.ok) begin
          r.status = ST_BAD_ARG;
        end else begin
          new_id     = id_counter;
          id_counter = id_counter + 32'd1;
          if (id_counter == 32'd0) id_counter = NEXT_ID_INIT;
          tbl_phase[new_slot] = PH_READY;
          tbl_id[new_slot]    = new_id;
          tbl_frame[new_slot] = rq.frame;
          tbl_space[new_slot] = rq.space;
          live_total++;
          created = 1'b1;
        end
      end
      OP_EXIT: begin
        if (cur_slot != 4'd0) tbl_phase[cur_slot] = PH_ZOMBIE;
      end
      default: begin
        if (rq.target >= SLOTS || tbl_phase[rq.target] == PH_UNUSED ||
            space_of_slot(rq.target) == 32'd0) begin
          r.status = ST_BAD_ARG;
        end else begin
          if (cur_slot != rq.target && tbl_phase[cur_slot] == PH_RUNNING)
            tbl_phase[cur_slot] = PH_READY;
          cur_slot              = rq.target;
          tbl_phase[rq.target]  = PH_RUNNING;
        end
      end
    endcase
    r.switched = (cur_slot != prev);
    r.slot     = created ? new_slot : cur_slot;
    r.id       = created ? new_id : tbl_id[cur_slot];
    r.frame    = r.switched ? tbl_frame[cur_slot] : rq.frame;
    r.space    = space_of_slot(cur_slot);
    r.live     = live_total[4:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Idle gaps: mostly none or short, a few long, with calm stretches of none
  // --------------------------------------------------------------------------
  function automatic int pick_gap(inout bit calm);
    int roll;
    if ($urandom_range(0, 63) == 0) calm = !calm;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Random request shaping
  // --------------------------------------------------------------------------
  // Mostly aim at a slot that is in use, sometimes anywhere
  function automatic logic [3:0] pick_target();
    logic [3:0] s;
    int         k;
    s = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) return s;
    for (k = 0; k < SLOTS; k++) begin
      if (tbl_phase[s] != PH_UNUSED) return s;
      s = s + 4'd1;
    end
    return s;
  endfunction

  function automatic logic [31:0] pick_word();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 32'd0;
    if (roll == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic sched_req_t rand_req(input opcode_t op);
    sched_req_t rq;
    rq.op     = op;
    rq.frame  = pick_word();
    rq.space  = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_word();
    rq.ok     = ($urandom_range(0, 15) != 0);
    rq.target = pick_target();
    return rq;
  endfunction

  function automatic opcode_t rand_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return OP_SCHED;
    if (roll < 55) return OP_CREATE;
    if (roll < 80) return OP_EXIT;
    return OP_SET;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one request and hold it until the transfer; record its result then
  task automatic offer(input sched_req_t rq, input logic typed, input sched_resp_t want);
    sched_resp_t pred;
    int          gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= rq.op;
    in_frame_in      <= rq.frame;
    in_address_space <= rq.space;
    in_resources_ok  <= rq.ok;
    in_target_slot   <= rq.target;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = advance_table(rq);
    owed_results.push_back(typed ? want : pred);
    sent++;
  endtask

  // Drain the block, then write kernel_space while nothing is in flight
  task automatic write_kernel_space(input logic [31:0] val);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    kernel_space_m = val;
  endtask

  // Directed requests; the hand-written results all start from reset state
  // with kernel_space at zero
  sched_row_t dir_rows [DIR_N] = '{
    // schedule with nothing ready: bootstrap keeps running, frame saved
    '{'{OP_SCHED, 32'hFFFF_FFFF, 32'h0, 1'b0, 4'd0}, 1'b1,
      '{ST_OK, 1'b0, 4'd0, 32'd1, 32'hFFFF_FFFF, 32'h0, 1'b0, 4'd0, 5'd1}},
    // exit of the bootstrap is ignored
    '{'{OP_EXIT, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1, 4'd15}, 1'b1,
      '{ST_OK, 1'b0, 4'd0, 32'd1, 32'h1234_5678, 32'h0, 1'b0, 4'd0, 5'd1}},
    // set to slot 0 with a zero kernel space is refused
    '{'{OP_SET, 32'h0, 32'h0, 1'b0, 4'd0}, 1'b1,
      '{ST_BAD_ARG, 1'b0, 4'd0, 32'd1, 32'h0, 32'h0, 1'b0, 4'd0, 5'd1}},
    // set to an unused slot is refused
    '{'{OP_SET, 32'h0, 32'h0, 1'b1, 4'd15}, 1'b1,
      '{ST_BAD_ARG, 1'b0, 4'd0, 32'd1, 32'h0, 32'h0, 1'b0, 4'd0, 5'd1}},
    // create with a zero space
    '{'{OP_CREATE, 32'hAAAA_5555, 32'h0, 1'b1, 4'd0}, 1'b1,
      '{ST_BAD_ARG, 1'b0, 4'd0, 32'd1, 32'hAAAA_5555, 32'h0, 1'b0, 4'd0, 5'd1}},
    // create with missing pages
    '{'{OP_CREATE, 32'h5555_AAAA, 32'hFFFF_FFFF, 1'b0, 4'd0}, 1'b1,
      '{ST_BAD_ARG, 1'b0, 4'd0, 32'd1, 32'h5555_AAAA, 32'h0, 1'b0, 4'd0, 5'd1}},
    '{'{OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 4'd0}, 1'b0, '0},
    '{'{OP_CREATE, 32'h0, 32'h1, 1'b1, 4'd0}, 1'b0, '0},
    '{'{OP_CREATE, 32'h0F0F_0F0F, 32'h8000_0000, 1'b1, 4'd0}, 1'b0, '0},
    // first real switch, then direct switch, then exit and reap
    '{'{OP_SCHED, 32'hC0DE_0000, 32'h0, 1'b0, 4'd0}, 1'b0, '0},
    '{'{OP_SET, 32'h0, 32'h0, 1'b0, 4'd3}, 1'b0, '0},
    '{'{OP_EXIT, 32'h0, 32'h0, 1'b0, 4'd0}, 1'b0, '0},
    '{'{OP_SCHED, 32'h7FFF_FFFF, 32'h0, 1'b0, 4'd0}, 1'b0, '0},
    '{'{OP_SET, 32'h0, 32'h0, 1'b0, 4'd3}, 1'b0, '0},
    // zombie revived by a set to itself
    '{'{OP_SET, 32'h0, 32'h0, 1'b0, 4'd1}, 1'b0, '0},
    '{'{OP_EXIT, 32'h0, 32'h0, 1'b0, 4'd0}, 1'b0, '0},
    '{'{OP_SET, 32'h0, 32'h0, 1'b0, 4'd1}, 1'b0, '0},
    // leave a zombie by a set: it stays unreaped, later revived from afar
    '{'{OP_EXIT, 32'h0, 32'h0, 1'b0, 4'd0}, 1'b0, '0},
    '{'{OP_SET, 32'h0, 32'h0, 1'b0, 4'd2}, 1'b0, '0},
    '{'{OP_SCHED, 32'h8000_0000, 32'h0, 1'b0, 4'd0}, 1'b0, '0},
    '{'{OP_SET, 32'h0, 32'h0, 1'b0, 4'd1}, 1'b0, '0},
    '{'{OP_SCHED, 32'h0, 32'h0, 1'b0, 4'd0}, 1'b0, '0},
    '{'{OP_SCHED, 32'hFFFF_FFFF, 32'h0, 1'b0, 4'd0}, 1'b0, '0},
    '{'{OP_SET, 32'h0, 32'h0, 1'b0, 4'd0}, 1'b0, '0}
  };

  initial begin : stimulus
    logic [31:0] settings [7];
    int          ph;
    int          roll;
    int          phase_end;
    settings[0] = 32'hFFFF_FFFF;
    settings[1] = $urandom;
    settings[2] = 32'h0;
    settings[3] = 32'h1;
    settings[4] = 32'h8000_0000;
    settings[5] = $urandom | 32'h1;
    settings[6] = 32'h7FFF_FFFF;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_kernel_space(32'h0);
    for (int i = 0; i < DIR_N; i++)
      offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    for (ph = 0; ph < 7; ph++) begin
      // the sender pauses here until every owed result has come back
      write_kernel_space(settings[ph]);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          offer(rand_req(rand_op()), 1'b0, '0);
        end else if (roll < 58) begin
          // fill the table with a burst of creates, which may run out of slots
          repeat ($urandom_range(4, 16)) offer(rand_req(OP_CREATE), 1'b0, '0);
        end else if (roll < 83) begin
          // task life: switch in, run a little, exit, get scheduled away
          offer(rand_req(OP_SET), 1'b0, '0);
          repeat ($urandom_range(0, 3)) offer(rand_req(OP_SCHED), 1'b0, '0);
          offer(rand_req(OP_EXIT), 1'b0, '0);
          offer(rand_req(OP_SCHED), 1'b0, '0);
        end else begin
          repeat ($urandom_range(3, 8)) offer(rand_req(OP_SCHED), 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  sched_resp_t want_r;
  int          stall_left = 0;
  bit          held = 1'b0;

  task automatic check_field(input string name, input logic [31:0] exp,
                             input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    // compare a result transfer against the oldest owed result
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $error("result transfer with nothing owed");
        mismatches++;
      end else begin
        want_r = owed_results.pop_front();
        check_field("status",      want_r.status,      out_status);
        check_field("switched",    want_r.switched,    out_switched);
        check_field("slot_out",    want_r.slot,        out_slot_out);
        check_field("id_out",      want_r.id,          out_id_out);
        check_field("frame_out",   want_r.frame,       out_frame_out);
        check_field("space_out",   want_r.space,       out_space_out);
        check_field("reaped",      want_r.reaped,      out_reaped);
        check_field("reaped_slot", want_r.reaped_slot, out_reaped_slot);
        check_field("live_count",  want_r.live,        out_live_count);
      end
      results_seen++;
    end
    // hold off once for a long stretch so the block backs up into its input
    if (!held && results_seen >= 300) begin
      held       = 1'b1;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(out_calm);
    end
  end

endmodule
